### rtl/pcrd_pkg.sv
package pcrd_pkg;

	// packed vector component and datapath widths
	localparam int CompW  = 21;
	localparam int RegW   = 3 * CompW;
	localparam int CoordW = 17;
	localparam int ProdW  = CompW + CoordW + 1;
	localparam int DiffW  = CompW + 1;
	localparam int DirW   = ProdW + 2;
	localparam int MagW   = 16;
	localparam int SqW    = 2 * MagW;
	localparam int SumW   = SqW + 2;
	localparam int QW     = 15;
	localparam int PW     = 69;
	localparam int OutW   = 16;
	localparam int ShW    = 5;
	localparam int ScaleDepth = QW + 1;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_EYE    = 2'd0,
		REG_CORNER = 2'd1,
		REG_HORIZ  = 2'd2,
		REG_VERT   = 2'd3
	} reg_idx_t;

	// one signed component out of a packed vector
	function automatic logic signed [CompW-1:0] comp(input logic [RegW-1:0] p, input int idx);
		comp = $signed(p[idx*CompW +: CompW]);
	endfunction

endpackage

### rtl/pcrd_scale.sv
module pcrd_scale import pcrd_pkg::*; (
	input  logic             clk,
	input  logic             ce,
	input  logic [SqW-1:0]   sq,
	input  logic [SumW-1:0]  ssum,
	output logic [QW-1:0]    q
);

	// per-stage search state: t = 2q-1, p = t*t*S, a = t*S
	logic        [QW-1:0] q_s [ScaleDepth];
	logic signed [PW-1:0] p_s [ScaleDepth];
	logic signed [PW-1:0] a_s [ScaleDepth];
	logic signed [PW-1:0] s_s [ScaleDepth];
	logic signed [PW-1:0] r_s [ScaleDepth];

	// stage zero: t = -1, target = m^2 * 2^30
	always_ff @(posedge clk) begin
		if (ce) begin
			q_s[0] <= '0;
			p_s[0] <= $signed(PW'(ssum));
			a_s[0] <= -$signed(PW'(ssum));
			s_s[0] <= $signed(PW'(ssum));
			r_s[0] <= $signed(PW'(sq) << 30);
		end
	end

	// one result bit per stage, msb first
	for (genvar k = 1; k < ScaleDepth; k++) begin : g_step
		localparam int B = QW - k;
		logic signed [PW-1:0] cand;
		logic                 take;

		assign cand = p_s[k-1] + (a_s[k-1] <<< (B + 2)) + (s_s[k-1] <<< (2 * B + 2));
		assign take = cand <= r_s[k-1];

		always_ff @(posedge clk) begin
			if (ce) begin
				q_s[k] <= take ? (q_s[k-1] | (QW'(1) << B)) : q_s[k-1];
				p_s[k] <= take ? cand : p_s[k-1];
				a_s[k] <= take ? (a_s[k-1] + (s_s[k-1] <<< (B + 1))) : a_s[k-1];
				s_s[k] <= s_s[k-1];
				r_s[k] <= r_s[k-1];
			end
		end
	end

	assign q = q_s[ScaleDepth-1];

endmodule

### rtl/pinhole_camera_ray_direction.sv
// throughput: one beat per cycle; a stalled output holds the whole pipeline
// latency is set mostly by the 16-stage unit-scale search, one result bit per stage after stage zero
// reset: arst_n clears all valid bits and the four frame registers to zero
// no clearing pass; input is accepted right after reset
module pinhole_camera_ray_direction import pcrd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [RegW-1:0]  cfg_data,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [39:0]      s_axis_tdata,   // screen_u, screen_v, zero pad
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // dir_x, dir_y, dir_z
	output logic             m_axis_tuser    // degenerate
);

	logic [RegW-1:0] eye_q, corner_q, horiz_q, vert_q;
	logic            ce;

	// frame registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_q    <= '0;
			corner_q <= '0;
			horiz_q  <= '0;
			vert_q   <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_EYE:    eye_q    <= cfg_data;
				REG_CORNER: corner_q <= cfg_data;
				REG_HORIZ:  horiz_q  <= cfg_data;
				REG_VERT:   vert_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// global advance
	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [ScaleDepth-1:0] v_sc, neg_x, neg_y, neg_z, deg_sc;

	logic signed [DiffW-1:0] diff_s1 [3];
	logic signed [ProdW-1:0] hu_s1 [3];
	logic signed [ProdW-1:0] vv_s1 [3];
	logic        [DirW-1:0]  mag_s2 [3];
	logic        [2:0]       neg_s2, neg_s3, neg_s4, neg_s5;
	logic        [DirW-1:0]  mag_s3 [3];
	logic        [ShW-1:0]   sh_s3;
	logic                    deg_s3, deg_s4, deg_s5;
	logic        [MagW-1:0]  m_s4 [3];
	logic        [SqW-1:0]   sq_s5 [3];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_sc <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_sc <= {v_sc[ScaleDepth-2:0], v_s5};
			m_axis_tvalid <= v_sc[ScaleDepth-1];
		end
	end

	// stage 1: span products and corner minus eye
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				diff_s1[i] <= DiffW'(comp(corner_q, i)) - DiffW'(comp(eye_q, i));
				hu_s1[i]   <= comp(horiz_q, i) * $signed({1'b0, s_axis_tdata[16:0]});
				vv_s1[i]   <= comp(vert_q, i) * $signed({1'b0, s_axis_tdata[33:17]});
			end
		end
	end

	// stage 2: direction sum, sign and magnitude
	always_ff @(posedge clk) begin
		logic signed [DirW-1:0] d;
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				d = (DirW'(diff_s1[i]) <<< 16) + DirW'(hu_s1[i]) + DirW'(vv_s1[i]);
				neg_s2[i] <= d[DirW-1];
				mag_s2[i] <= d[DirW-1] ? DirW'(-d) : DirW'(d);
			end
		end
	end

	// stage 3: common shift that brings the largest below 2^16
	logic [DirW-1:0] big;
	logic [ShW-1:0]  sh;
	assign big = mag_s2[0] | mag_s2[1] | mag_s2[2];
	always_comb begin
		sh = '0;
		for (int i = MagW; i < DirW; i++) begin
			if (big[i]) sh = ShW'(i - MagW + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			sh_s3  <= sh;
			deg_s3 <= big == '0;
		end
	end

	// stage 4: normalize magnitudes
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) m_s4[i] <= MagW'(mag_s3[i] >> sh_s3);
			neg_s4 <= neg_s3;
			deg_s4 <= deg_s3;
		end
	end

	// stage 5: squares
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) sq_s5[i] <= m_s4[i] * m_s4[i];
			neg_s5 <= neg_s4;
			deg_s5 <= deg_s4;
		end
	end

	// squared length and per-lane unit scale search
	logic [SumW-1:0] ssum;
	logic [QW-1:0]   qx, qy, qz;
	assign ssum = SumW'(sq_s5[0]) + SumW'(sq_s5[1]) + SumW'(sq_s5[2]);

	pcrd_scale u_scale_x (.clk(clk), .ce(ce), .sq(sq_s5[0]), .ssum(ssum), .q(qx));
	pcrd_scale u_scale_y (.clk(clk), .ce(ce), .sq(sq_s5[1]), .ssum(ssum), .q(qy));
	pcrd_scale u_scale_z (.clk(clk), .ce(ce), .sq(sq_s5[2]), .ssum(ssum), .q(qz));

	// sign and degenerate flag ride alongside the search
	always_ff @(posedge clk) begin
		if (ce) begin
			neg_x  <= {neg_x[ScaleDepth-2:0], neg_s5[0]};
			neg_y  <= {neg_y[ScaleDepth-2:0], neg_s5[1]};
			neg_z  <= {neg_z[ScaleDepth-2:0], neg_s5[2]};
			deg_sc <= {deg_sc[ScaleDepth-2:0], deg_s5};
		end
	end

	// output register: apply sign, zero on degenerate
	logic [OutW-1:0] ox, oy, oz;
	logic            odeg;
	assign odeg = deg_sc[ScaleDepth-1];
	assign ox = odeg ? '0 : (neg_x[ScaleDepth-1] ? -OutW'(qx) : OutW'(qx));
	assign oy = odeg ? '0 : (neg_y[ScaleDepth-1] ? -OutW'(qy) : OutW'(qy));
	assign oz = odeg ? '0 : (neg_z[ScaleDepth-1] ? -OutW'(qz) : OutW'(qz));

	always_ff @(posedge clk) begin
		if (ce) begin
			m_axis_tdata <= {oz, oy, ox};
			m_axis_tuser <= odeg;
		end
	end

	// degenerate results carry a zero vector
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("degenerate result with nonzero direction");

	// a proper direction never comes out all zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != '0)
		else $error("zero direction without degenerate flag");

	// components stay within unit range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) >= -16384
			&& $signed(m_axis_tdata[31:16]) >= -16384
			&& $signed(m_axis_tdata[47:32]) >= -16384
			&& $signed(m_axis_tdata[15:0]) <= 16384
			&& $signed(m_axis_tdata[31:16]) <= 16384
			&& $signed(m_axis_tdata[47:32]) <= 16384)
		else $error("direction component out of range");

	// a stalled pipeline takes no input
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken during stall");

endmodule

### sim/pinhole_camera_ray_direction_tb.sv
`timescale 1ns / 1ps

module pinhole_camera_ray_direction_tb import pcrd_pkg::*; ;

	localparam int StallLimit = 5000;
	localparam int DrainCycles = 40;

	typedef struct packed {
		logic [15:0] dx;
		logic [15:0] dy;
		logic [15:0] dz;
		logic        degen;
	} ray_dir_t;

	// direction predictor and store of expected ray directions
	class ray_dir_scoreboard;
		logic [RegW-1:0] frame [4];
		ray_dir_t expected_dirs [$];
		int mismatches;

		function new();
			foreach (frame[i]) frame[i] = '0;
			mismatches = 0;
		endfunction

		function longint comp_of(logic [RegW-1:0] p, int idx);
			logic signed [CompW-1:0] c;
			c = p[idx*CompW +: CompW];
			return longint'(c);
		endfunction

		// round-half-up of 16384 * m / sqrt(s), with 64-bit wraparound
		function logic [63:0] unit_mag(logic [63:0] m, logic [63:0] s);
			logic [63:0] lo, hi, mid, t, rhs;
			lo = 0;
			hi = 16384;
			rhs = (m * m) << 30;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				t = 2 * mid - 1;
				if (t * t * s <= rhs) lo = mid;
				else hi = mid - 1;
			end
			return lo;
		endfunction

		function void note_coord(logic [CoordW-1:0] u, logic [CoordW-1:0] v);
			longint d;
			logic [63:0] mag [3];
			logic neg [3];
			logic [63:0] big, s, q;
			logic [15:0] dq [3];
			int sh;
			ray_dir_t r;
			big = 0;
			s = 0;
			sh = 0;
			for (int i = 0; i < 3; i++) begin
				d = comp_of(frame[REG_CORNER], i) * 65536
					+ comp_of(frame[REG_HORIZ], i) * longint'({1'b0, u})
					+ comp_of(frame[REG_VERT], i) * longint'({1'b0, v})
					- comp_of(frame[REG_EYE], i) * 65536;
				neg[i] = d < 0;
				mag[i] = neg[i] ? -d : d;
				if (mag[i] > big) big = mag[i];
			end
			if (big == 0) begin
				r = '{dx: 0, dy: 0, dz: 0, degen: 1'b1};
			end else begin
				while ((big >> sh) >= 65536) sh++;
				for (int i = 0; i < 3; i++) begin
					mag[i] = mag[i] >> sh;
					s += mag[i] * mag[i];
				end
				for (int i = 0; i < 3; i++) begin
					q = unit_mag(mag[i], s);
					dq[i] = neg[i] ? 16'(-q) : 16'(q);
				end
				r = '{dx: dq[0], dy: dq[1], dz: dq[2], degen: 1'b0};
			end
			expected_dirs.push_back(r);
		endfunction

		function void check_dir(ray_dir_t got);
			ray_dir_t exp_dir;
			if (expected_dirs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: x=%h y=%h z=%h degen=%b",
						got.dx, got.dy, got.dz, got.degen);
				return;
			end
			exp_dir = expected_dirs.pop_front();
			if (got !== exp_dir) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp x=%h y=%h z=%h degen=%b got x=%h y=%h z=%h degen=%b",
						exp_dir.dx, exp_dir.dy, exp_dir.dz, exp_dir.degen,
						got.dx, got.dy, got.dz, got.degen);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [RegW-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata;    // screen_u, screen_v, zero pad
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;    // dir_x, dir_y, dir_z
	logic m_axis_tuser;           // degenerate

	ray_dir_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int quiet_cycles;

	pinhole_camera_ray_direction dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver side with random stalls and a long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// result beat check
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_dir('{dx: m_axis_tdata[15:0], dy: m_axis_tdata[31:16],
				dz: m_axis_tdata[47:32], degen: m_axis_tuser});
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [RegW-1:0] pack3(int x, int y, int z);
		logic [CompW-1:0] cx, cy, cz;
		cx = x[CompW-1:0];
		cy = y[CompW-1:0];
		cz = z[CompW-1:0];
		return {cz, cy, cx};
	endfunction

	task automatic send_coord(logic [CoordW-1:0] u, logic [CoordW-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, v, u};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_coord(u, v);
	endtask

	// drain the pipeline, then let it settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_dirs.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// one write beat; the caller drops the write enable after the last one
	task automatic write_reg(reg_idx_t idx, logic [RegW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.frame[idx] = val;
	endtask

	task automatic load_frame(logic [RegW-1:0] eye, logic [RegW-1:0] corner,
		logic [RegW-1:0] horiz, logic [RegW-1:0] vert);
		wait_idle();
		write_reg(REG_EYE, eye);
		write_reg(REG_CORNER, corner);
		write_reg(REG_HORIZ, horiz);
		write_reg(REG_VERT, vert);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CoordW-1:0] rand_coord();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'h1FFFF;
			3: return 17'($urandom_range(131071));
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	function automatic logic [RegW-1:0] rand_vec();
		logic [RegW-1:0] r;
		r = RegW'({$urandom, $urandom});
		// mostly modest magnitudes so that rays stay well spread
		if ($urandom_range(3) != 0)
			r = pack3($urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
				$urandom_range(8191) - 4096);
		return r;
	endfunction

	task automatic random_run(int count);
		for (int i = 0; i < count; i++) send_coord(rand_coord(), rand_coord());
	endtask

	// main sequence
	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_EYE;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame: every ray degenerate
		send_coord(17'd0, 17'd0);
		send_coord(17'h1FFFF, 17'h1FFFF);

		// textbook camera at the origin looking down -z
		load_frame(pack3(0, 0, 0), pack3(-2048, -1024, -1024),
			pack3(4096, 0, 0), pack3(0, 2048, 0));
		send_coord(17'd0, 17'd0);
		send_coord(17'd65536, 17'd0);
		send_coord(17'd0, 17'd65536);
		send_coord(17'd65536, 17'd65536);
		send_coord(17'd32768, 17'd32768);
		send_coord(17'h1FFFF, 17'h1FFFF);
		send_coord(17'h15555, 17'h0AAAA);

		// eye on the corner: zero direction at the origin of the screen
		load_frame(pack3(100, -200, 300), pack3(100, -200, 300),
			pack3(1, 0, 0), pack3(0, 0, -1));
		send_coord(17'd0, 17'd0);
		send_coord(17'd1, 17'd0);
		send_coord(17'd0, 17'd1);
		send_coord(17'h1FFFF, 17'd65536);

		// largest positive and negative components
		load_frame(pack3(-1048576, -1048576, -1048576), pack3(1048575, 1048575, 1048575),
			pack3(1048575, 1048575, 1048575), pack3(1048575, -1048576, 1048575));
		send_coord(17'd0, 17'd0);
		send_coord(17'h1FFFF, 17'h1FFFF);
		send_coord(17'd65536, 17'h1FFFF);
		load_frame(pack3(1048575, 1048575, 1048575), pack3(-1048576, -1048576, -1048576),
			pack3(-1048576, -1048576, -1048576), pack3(-1048576, 1048575, -1048576));
		send_coord(17'd0, 17'd0);
		send_coord(17'h1FFFF, 17'h1FFFF);
		send_coord(17'd65536, 17'h0FFFF);

		// random frames across all idling mixes
		for (int p = 0; p < 8; p++) begin
			load_frame(rand_vec(), rand_vec(), rand_vec(), rand_vec());
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			// back up the output so the input side has to stall
			if (p == 0) hold_cycles = 300;
			random_run(105);
		end

		wait_idle();
		if (sb.mismatches == 0 && sb.expected_dirs.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
rtl/pcrd_pkg.sv
rtl/pcrd_scale.sv
rtl/pinhole_camera_ray_direction.sv
sim/pinhole_camera_ray_direction_tb.sv
